// ===== hw/rtl/lav_pkg.sv =====
// lav_pkg: shared widths and latency helper for the look-at view matrix unit
// used by lav_norm and look_at_view_matrix_unit, depends on nothing
package lav_pkg;

  localparam int DATA_W         = 32;  // port word width
  localparam int UNIT_FRAC_BITS = 30;  // fraction bits of the unit rows
  localparam int MAG_W          = 31;  // scaled magnitude, top bit at 2^30
  localparam int SUM_W          = 64;  // sum of three squares
  localparam int ROOT_W         = 32;  // integer square root of SUM_W bits

  // pipeline depth of one normalizer
  function automatic int norm_lat(input int unit_frac);
    return ROOT_W + unit_frac + 9;
  endfunction

endpackage

// ===== hw/rtl/lav_norm.sv =====
// lav_norm: pipelined 3-vector normalizer (scale, sum of squares, isqrt, divide)
// uses lav_pkg; one vector per enabled cycle
module lav_norm
  import lav_pkg::*;
#(
  parameter int IN_W           = 33,
  parameter int UNIT_FRAC_BITS = lav_pkg::UNIT_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [2:0][IN_W-1:0]            vin,
  output logic [2:0][UNIT_FRAC_BITS+1:0]  vout
);

  localparam int QW  = UNIT_FRAC_BITS + 2;
  localparam int NW  = MAG_W + UNIT_FRAC_BITS + 1;
  localparam int SHW = $clog2(IN_W + 1);
  localparam int RW  = ROOT_W + 3;

  // front stages
  logic [IN_W-1:0]  mag1_r [3];
  logic [2:0]       sgn1_r;
  logic [IN_W-1:0]  mag2_r [3];
  logic [2:0]       sgn2_r;
  logic [IN_W-1:0]  mx2_r;
  logic [IN_W-1:0]  mx_nxt;
  logic [MAG_W-1:0] m3_r [3];
  logic [2:0]       sgn3_r;
  logic             zero3_r;
  logic [SHW-1:0]   msb_pos;
  logic [SHW-1:0]   sh_amt;
  logic [IN_W+MAG_W-1:0] ext [3];
  logic [MAG_W-1:0] m4_r [3];
  logic [2*MAG_W-1:0] sq4_r [3];
  logic [2:0]       sgn4_r;
  logic             zero4_r;

  // square root stages
  logic [RW-1:0]     sq_rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root_r [ROOT_W+1];
  logic [SUM_W-1:0]  sq_x_r    [ROOT_W+1];
  logic [MAG_W-1:0]  sq_m_r    [ROOT_W+1][3];
  logic [2:0]        sq_sgn_r  [ROOT_W+1];
  logic              sq_zero_r [ROOT_W+1];
  logic [RW-1:0]     sq_try    [ROOT_W];
  logic [RW-1:0]     sq_trial  [ROOT_W];
  logic [RW-1:0]     sq_rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] sq_root_nxt [ROOT_W];

  // divide stages
  logic [NW-1:0]     num [3];
  logic [ROOT_W-1:0] dv_rem_r  [QW+1][3];
  logic [QW-1:0]     dv_num_r  [QW+1][3];
  logic [QW-1:0]     dv_q_r    [QW+1][3];
  logic [ROOT_W-1:0] dv_len_r  [QW+1];
  logic [2:0]        dv_sgn_r  [QW+1];
  logic              dv_zero_r [QW+1];
  logic [ROOT_W:0]   dv_try     [QW][3];
  logic [ROOT_W-1:0] dv_rem_nxt [QW][3];
  logic [QW-1:0]     dv_q_nxt   [QW][3];

  always_comb begin
    mx_nxt = mag1_r[0];
    if (mag1_r[1] > mx_nxt) mx_nxt = mag1_r[1];
    if (mag1_r[2] > mx_nxt) mx_nxt = mag1_r[2];
    msb_pos = '0;
    for (int j = 0; j < IN_W; j++) begin
      if (mx2_r[j]) msb_pos = SHW'(j);
    end
    sh_amt = msb_pos + SHW'(1);
    // top set bit lands on bit 30, low bits truncate
    for (int i = 0; i < 3; i++) begin
      ext[i] = {mag2_r[i], {MAG_W{1'b0}}} >> sh_amt;
    end
  end

  always_comb begin
    for (int k = 0; k < ROOT_W; k++) begin
      sq_try[k]   = {sq_rem_r[k][ROOT_W:0], sq_x_r[k][SUM_W-1 -: 2]};
      sq_trial[k] = {1'b0, sq_root_r[k], 2'b01};
      if (sq_try[k] >= sq_trial[k]) begin
        sq_rem_nxt[k]  = sq_try[k] - sq_trial[k];
        sq_root_nxt[k] = {sq_root_r[k][ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_nxt[k]  = sq_try[k];
        sq_root_nxt[k] = {sq_root_r[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // rounding half the divisor folded into the numerator
      num[i] = {1'b0, sq_m_r[ROOT_W][i], {UNIT_FRAC_BITS{1'b0}}}
             + NW'(sq_root_r[ROOT_W] >> 1);
    end
    for (int j = 0; j < QW; j++) begin
      for (int i = 0; i < 3; i++) begin
        dv_try[j][i] = {dv_rem_r[j][i], dv_num_r[j][i][QW-1]};
        if (dv_try[j][i] >= {1'b0, dv_len_r[j]}) begin
          dv_rem_nxt[j][i] = ROOT_W'(dv_try[j][i] - {1'b0, dv_len_r[j]});
          dv_q_nxt[j][i]   = {dv_q_r[j][i][QW-2:0], 1'b1};
        end else begin
          dv_rem_nxt[j][i] = ROOT_W'(dv_try[j][i]);
          dv_q_nxt[j][i]   = {dv_q_r[j][i][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1_r[i] <= vin[i][IN_W-1] ? IN_W'(-vin[i]) : vin[i];
        sgn1_r[i] <= vin[i][IN_W-1];
        mag2_r[i] <= mag1_r[i];
        m3_r[i]   <= ext[i][MAG_W-1:0];
        m4_r[i]   <= m3_r[i];
        sq4_r[i]  <= m3_r[i] * m3_r[i];
      end
      sgn2_r  <= sgn1_r;
      mx2_r   <= mx_nxt;
      sgn3_r  <= sgn2_r;
      zero3_r <= (mx2_r == '0);
      sgn4_r  <= sgn3_r;
      zero4_r <= zero3_r;

      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_x_r[0]    <= SUM_W'(sq4_r[0]) + SUM_W'(sq4_r[1]) + SUM_W'(sq4_r[2]);
      sq_m_r[0]    <= m4_r;
      sq_sgn_r[0]  <= sgn4_r;
      sq_zero_r[0] <= zero4_r;
      for (int k = 0; k < ROOT_W; k++) begin
        sq_rem_r[k+1]  <= sq_rem_nxt[k];
        sq_root_r[k+1] <= sq_root_nxt[k];
        sq_x_r[k+1]    <= {sq_x_r[k][SUM_W-3:0], 2'b00};
        sq_m_r[k+1]    <= sq_m_r[k];
        sq_sgn_r[k+1]  <= sq_sgn_r[k];
        sq_zero_r[k+1] <= sq_zero_r[k];
      end

      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= ROOT_W'(num[i][NW-1:QW]);
        dv_num_r[0][i] <= num[i][QW-1:0];
        dv_q_r[0][i]   <= '0;
      end
      dv_len_r[0]  <= sq_root_r[ROOT_W];
      dv_sgn_r[0]  <= sq_sgn_r[ROOT_W];
      dv_zero_r[0] <= sq_zero_r[ROOT_W];
      for (int j = 0; j < QW; j++) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[j+1][i] <= dv_rem_nxt[j][i];
          dv_num_r[j+1][i] <= {dv_num_r[j][i][QW-2:0], 1'b0};
          dv_q_r[j+1][i]   <= dv_q_nxt[j][i];
        end
        dv_len_r[j+1]  <= dv_len_r[j];
        dv_sgn_r[j+1]  <= dv_sgn_r[j];
        dv_zero_r[j+1] <= dv_zero_r[j];
      end

      for (int i = 0; i < 3; i++) begin
        if (dv_zero_r[QW]) begin
          vout[i] <= '0;
        end else if (dv_sgn_r[QW][i]) begin
          vout[i] <= -dv_q_r[QW][i];
        end else begin
          vout[i] <= dv_q_r[QW][i];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/look_at_view_matrix_unit.sv =====
// look_at_view_matrix_unit: camera view matrix from eye, target and up hint
// uses lav_pkg and lav_norm
// pipeline depth set mostly by the two normalizers in series (bit-per-stage
// isqrt and divide), forward and up side by side first and then side
// throughput one word per cycle; the whole pipeline holds while out_stall
// keeps a finished word waiting; reset clears only the valid bits
module look_at_view_matrix_unit
  import lav_pkg::*;
#(
  parameter int UNIT_FRAC_BITS = lav_pkg::UNIT_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_eye_x,
  input  logic signed [DATA_W-1:0] in_eye_y,
  input  logic signed [DATA_W-1:0] in_eye_z,
  input  logic signed [DATA_W-1:0] in_target_x,
  input  logic signed [DATA_W-1:0] in_target_y,
  input  logic signed [DATA_W-1:0] in_target_z,
  input  logic signed [DATA_W-1:0] in_up_hint_x,
  input  logic signed [DATA_W-1:0] in_up_hint_y,
  input  logic signed [DATA_W-1:0] in_up_hint_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_side_x,
  output logic signed [DATA_W-1:0] out_side_y,
  output logic signed [DATA_W-1:0] out_side_z,
  output logic signed [DATA_W-1:0] out_true_up_x,
  output logic signed [DATA_W-1:0] out_true_up_y,
  output logic signed [DATA_W-1:0] out_true_up_z,
  output logic signed [DATA_W-1:0] out_back_x,
  output logic signed [DATA_W-1:0] out_back_y,
  output logic signed [DATA_W-1:0] out_back_z,
  output logic signed [DATA_W-1:0] out_shift_x,
  output logic signed [DATA_W-1:0] out_shift_y,
  output logic signed [DATA_W-1:0] out_shift_z
);

  localparam int UW   = UNIT_FRAC_BITS + 2;
  localparam int XW   = 2 * UW;
  localparam int NLAT = norm_lat(UNIT_FRAC_BITS);
  localparam int LAT  = 9 + 2 * NLAT;
  localparam int FD_N = NLAT + 7;
  localparam int ED_N = 5 + 2 * NLAT;
  localparam int PW   = UW + DATA_W;
  localparam int AW   = PW + 2;
  localparam logic signed [UW-1:0] UNIT_U = UW'(1) << UNIT_FRAC_BITS;
  localparam logic signed [DATA_W-1:0] UNIT_ONE = DATA_W'(64'd1 << UNIT_FRAC_BITS);

  function automatic logic signed [DATA_W-1:0] rnd_sat(
    input logic signed [AW-1:0] acc, input logic neg);
    logic [AW-1:0] mag;
    logic [AW-1:0] rnd;
    logic          is_neg;
    mag    = acc[AW-1] ? AW'(-acc) : AW'(acc);
    rnd    = (mag + (AW'(1) << (UNIT_FRAC_BITS - 1))) >> UNIT_FRAC_BITS;
    is_neg = acc[AW-1] ^ neg;
    if (!is_neg) begin
      if (rnd > AW'({1'b0, {(DATA_W-1){1'b1}}})) return {1'b0, {(DATA_W-1){1'b1}}};
      return DATA_W'(rnd);
    end
    if (rnd > AW'({1'b1, {(DATA_W-1){1'b0}}})) return {1'b1, {(DATA_W-1){1'b0}}};
    return DATA_W'(-rnd);
  endfunction

  logic                     en;
  logic [LAT-1:0]           vld_r;

  logic signed [DATA_W-1:0] eye_r [3];
  logic signed [DATA_W:0]   fwd_r [3];
  logic signed [DATA_W-1:0] up_r  [3];

  logic [2:0][DATA_W:0]     fwd_pk;
  logic [2:0][DATA_W-1:0]   up_pk;
  logic [2:0][XW-1:0]       sc_pk;
  logic [2:0][UW-1:0]       f_pk;
  logic [2:0][UW-1:0]       u_pk;
  logic [2:0][UW-1:0]       s_pk;
  logic signed [UW-1:0]     f_v [3];
  logic signed [UW-1:0]     u_v [3];
  logic signed [UW-1:0]     s_v [3];

  logic signed [XW-1:0]     pf_r [6];
  logic signed [XW-1:0]     sc_r [3];
  logic signed [XW-1:0]     ps_r [6];
  logic signed [XW-1:0]     tc_r [3];
  logic [XW-1:0]            tc_mag [3];
  logic [XW-1:0]            tc_rnd [3];
  logic signed [UW-1:0]     t_nxt [3];
  logic signed [UW-1:0]     t_r [3];

  logic signed [UW-1:0]     fd_r [FD_N][3];
  logic signed [DATA_W-1:0] ed_r [ED_N][3];
  logic signed [UW-1:0]     sd_r [5][3];
  logic signed [UW-1:0]     td_r [2][3];

  logic signed [PW-1:0]     pd_r  [3][3];
  logic signed [AW-1:0]     acc_r [3];

  logic signed [UW-1:0]     side_r [3];
  logic signed [UW-1:0]     tup_r  [3];
  logic signed [UW-1:0]     back_r [3];
  logic signed [DATA_W-1:0] shift_r [3];

  assign in_stall  = vld_r[LAT-1] & out_stall;
  assign en        = ~in_stall;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fwd_pk[i] = fwd_r[i];
      up_pk[i]  = up_r[i];
      sc_pk[i]  = sc_r[i];
      f_v[i]    = $signed(f_pk[i]);
      u_v[i]    = $signed(u_pk[i]);
      s_v[i]    = $signed(s_pk[i]);
    end
  end

  lav_norm #(.IN_W(DATA_W + 1), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_norm_fwd (
    .clk (clk), .en (en), .vin (fwd_pk), .vout (f_pk)
  );

  lav_norm #(.IN_W(DATA_W), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_norm_up (
    .clk (clk), .en (en), .vin (up_pk), .vout (u_pk)
  );

  lav_norm #(.IN_W(XW), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_norm_side (
    .clk (clk), .en (en), .vin (sc_pk), .vout (s_pk)
  );

  // true up rounded back to the unit format and clamped to one
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tc_mag[i] = tc_r[i][XW-1] ? XW'(-tc_r[i]) : XW'(tc_r[i]);
      tc_rnd[i] = (tc_mag[i] + (XW'(1) << (UNIT_FRAC_BITS - 1))) >> UNIT_FRAC_BITS;
      if (tc_rnd[i] > XW'(UNIT_U)) tc_rnd[i] = XW'(UNIT_U);
      t_nxt[i] = tc_r[i][XW-1] ? -UW'(tc_rnd[i]) : UW'(tc_rnd[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eye_r[0] <= in_eye_x;
      eye_r[1] <= in_eye_y;
      eye_r[2] <= in_eye_z;
      fwd_r[0] <= (DATA_W+1)'(in_target_x) - (DATA_W+1)'(in_eye_x);
      fwd_r[1] <= (DATA_W+1)'(in_target_y) - (DATA_W+1)'(in_eye_y);
      fwd_r[2] <= (DATA_W+1)'(in_target_z) - (DATA_W+1)'(in_eye_z);
      up_r[0]  <= in_up_hint_x;
      up_r[1]  <= in_up_hint_y;
      up_r[2]  <= in_up_hint_z;

      // side before normalizing: forward cross up
      pf_r[0] <= f_v[1] * u_v[2];
      pf_r[1] <= f_v[2] * u_v[1];
      pf_r[2] <= f_v[2] * u_v[0];
      pf_r[3] <= f_v[0] * u_v[2];
      pf_r[4] <= f_v[0] * u_v[1];
      pf_r[5] <= f_v[1] * u_v[0];
      sc_r[0] <= pf_r[0] - pf_r[1];
      sc_r[1] <= pf_r[2] - pf_r[3];
      sc_r[2] <= pf_r[4] - pf_r[5];

      // true up: side cross forward
      ps_r[0] <= s_v[1] * fd_r[NLAT+1][2];
      ps_r[1] <= s_v[2] * fd_r[NLAT+1][1];
      ps_r[2] <= s_v[2] * fd_r[NLAT+1][0];
      ps_r[3] <= s_v[0] * fd_r[NLAT+1][2];
      ps_r[4] <= s_v[0] * fd_r[NLAT+1][1];
      ps_r[5] <= s_v[1] * fd_r[NLAT+1][0];
      tc_r[0] <= ps_r[0] - ps_r[1];
      tc_r[1] <= ps_r[2] - ps_r[3];
      tc_r[2] <= ps_r[4] - ps_r[5];
      t_r     <= t_nxt;

      fd_r[0] <= f_v;
      for (int j = 1; j < FD_N; j++) fd_r[j] <= fd_r[j-1];
      ed_r[0] <= eye_r;
      for (int j = 1; j < ED_N; j++) ed_r[j] <= ed_r[j-1];
      sd_r[0] <= s_v;
      for (int j = 1; j < 5; j++) sd_r[j] <= sd_r[j-1];
      td_r[0] <= t_r;
      td_r[1] <= td_r[0];

      for (int i = 0; i < 3; i++) begin
        pd_r[0][i] <= sd_r[2][i] * ed_r[ED_N-1][i];
        pd_r[1][i] <= t_r[i] * ed_r[ED_N-1][i];
        pd_r[2][i] <= fd_r[NLAT+4][i] * ed_r[ED_N-1][i];
      end
      for (int r = 0; r < 3; r++) begin
        acc_r[r] <= AW'(pd_r[r][0]) + AW'(pd_r[r][1]) + AW'(pd_r[r][2]);
      end

      side_r <= sd_r[4];
      tup_r  <= td_r[1];
      for (int i = 0; i < 3; i++) back_r[i] <= -fd_r[NLAT+6][i];
      shift_r[0] <= rnd_sat(acc_r[0], 1'b1);
      shift_r[1] <= rnd_sat(acc_r[1], 1'b1);
      shift_r[2] <= rnd_sat(acc_r[2], 1'b0);
    end
  end

  assign out_side_x    = DATA_W'(side_r[0]);
  assign out_side_y    = DATA_W'(side_r[1]);
  assign out_side_z    = DATA_W'(side_r[2]);
  assign out_true_up_x = DATA_W'(tup_r[0]);
  assign out_true_up_y = DATA_W'(tup_r[1]);
  assign out_true_up_z = DATA_W'(tup_r[2]);
  assign out_back_x    = DATA_W'(back_r[0]);
  assign out_back_y    = DATA_W'(back_r[1]);
  assign out_back_z    = DATA_W'(back_r[2]);
  assign out_shift_x   = shift_r[0];
  assign out_shift_y   = shift_r[1];
  assign out_shift_z   = shift_r[2];

`ifndef NO_ASSERTIONS
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid straight after reset");

  a_back_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_back_x <= UNIT_ONE && out_back_x >= -UNIT_ONE &&
                   out_back_y <= UNIT_ONE && out_back_y >= -UNIT_ONE &&
                   out_back_z <= UNIT_ONE && out_back_z >= -UNIT_ONE))
    else $error("back row component beyond unit");

  a_true_up_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_true_up_x <= UNIT_ONE && out_true_up_x >= -UNIT_ONE &&
                   out_true_up_y <= UNIT_ONE && out_true_up_y >= -UNIT_ONE &&
                   out_true_up_z <= UNIT_ONE && out_true_up_z >= -UNIT_ONE))
    else $error("true up component beyond unit");
`endif

endmodule
